// ----- src/sdd_pkg.sv -----
`timescale 1ns / 1ps
package sdd_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DELAY     = 3'd0,
    REG_FEEDBACK  = 3'd1,
    REG_MIX       = 3'd2,
    REG_THRESHOLD = 3'd3,
    REG_SLOPE     = 3'd4,
    REG_ATTACK    = 3'd5,
    REG_RELEASE   = 3'd6
  } cfg_reg_t;

  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 17;
  localparam int DELAY_W = 17;
  localparam int GAIN_W  = 17;   // Q1.16 gains below 2.0, shared multiplier B operand
  localparam int COEF_W  = 16;
  localparam int THR_W   = 13;
  localparam int LOG_W   = 16;

  localparam int ROUND_HALF = 32768;
  localparam int UNITY_GAIN = 65536;

  localparam logic [DELAY_W-1:0] RST_DELAY     = 17'd22050;
  localparam logic [COEF_W-1:0]  RST_FEEDBACK  = 16'd19661;
  localparam logic [GAIN_W-1:0]  RST_MIX       = 17'd32768;
  localparam logic [THR_W-1:0]   RST_THRESHOLD = -13'sd850;
  localparam logic [COEF_W-1:0]  RST_SLOPE     = 16'd49152;
  localparam logic [COEF_W-1:0]  RST_ATTACK    = 16'd65387;
  localparam logic [COEF_W-1:0]  RST_RELEASE   = 16'd65521;

  typedef enum logic [14:0] {
    S_IDLE = 15'b000000000000001,
    S_RED  = 15'b000000000000010,
    S_WR   = 15'b000000000000100,
    S_RD   = 15'b000000000001000,
    S_E1   = 15'b000000000010000,
    S_E2   = 15'b000000000100000,
    S_E3   = 15'b000000001000000,
    S_G1   = 15'b000000010000000,
    S_G2   = 15'b000000100000000,
    S_G3   = 15'b000001000000000,
    S_W1   = 15'b000010000000000,
    S_W2   = 15'b000100000000000,
    S_W3   = 15'b001000000000000,
    S_W4   = 15'b010000000000000,
    S_DONE = 15'b100000000000000
  } state_t;

endpackage

// ----- src/sdd_mul.sv -----
`timescale 1ns / 1ps
module sdd_mul
  import sdd_pkg::*;
#(
  parameter int A_W = 17
) (
  input  logic                      clk,
  input  logic signed [A_W-1:0]     a,
  input  logic        [GAIN_W-1:0]  b,
  output logic signed [A_W+GAIN_W:0] p
);

  logic signed [A_W+GAIN_W:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= a * $signed({1'b0, b});
  end

  assign p = p_r;

endmodule

// ----- src/sdd_line.sv -----
`timescale 1ns / 1ps
module sdd_line #(
  parameter int DEPTH = 131072,
  parameter int AW    = 17,
  parameter int W     = 16
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/stereo_ducking_delay.sv -----
`timescale 1ns / 1ps
// Stereo delay with a per-channel ducking compressor on the wet path.
// Input channel: in_valid / in_stall carry one stereo frame per beat
// (in_left_sample, in_right_sample, in_frame_last). Output channel:
// out_valid / out_stall carry one result beat per input frame.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr at the
// clock edge; unused indexes are ignored. Write only while idle.
// Once an input beat is taken, the sequencer runs the delay reduction
// steps (none at the default depth), memory write and read, then envelope,
// gain and wet states per channel, and takes the next beat after loading.
// All multiplies of both channels run one after the other through a
// single registered multiplier, under the sequencer.
// in_stall is high from acceptance until the frame is finished.
// A finished frame sits in the output register; the next frame may be
// taken meanwhile, and if it finishes while out_stall still holds the
// old beat, the sequencer waits before loading it.
// Reset (rst_n low, synchronous) loads the register defaults, clears the
// envelopes and the write address. The delay memories are not swept:
// a wrap flag and the write address mark which entries hold written
// samples; all others read as zero.
module stereo_ducking_delay
  import sdd_pkg::*;
#(
  parameter int DEPTH       = 131072,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0] in_right_sample,
  input  logic                          in_frame_last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_right_out,
  output logic                          out_last,
  input  logic                          cfg_we,
  input  logic [CFG_AW-1:0]             cfg_addr,
  input  logic [CFG_DW-1:0]             cfg_wdata
);

  localparam int SB  = SAMPLE_BITS;
  localparam int AW  = $clog2(DEPTH);
  localparam int MW  = (SB + 1 > 16) ? SB + 1 : 16;
  localparam int PW  = MW + GAIN_W + 1;
  localparam int RW  = ((AW > DELAY_W) ? AW : DELAY_W) + 2;

  function automatic int red_steps(input longint dep);
    int n;
    n = 0;
    for (int k = 0; k < 21; k++) begin
      if ((dep << k) <= longint'((1 << DELAY_W) - 1)) n++;
    end
    return n;
  endfunction

  localparam int RED_STEPS = red_steps(longint'(DEPTH));
  localparam logic [SB-1:0] HALF = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [MW:0] SMAX = (MW+1)'((longint'(1) << (SB-1)) - 1);
  localparam logic signed [MW:0] SMIN = -SMAX - 1;

  // configuration
  logic [DELAY_W-1:0]      delay_r;
  logic [COEF_W-1:0]       fb_r;
  logic [GAIN_W-1:0]       mix_r;
  logic signed [THR_W-1:0] thr_r;
  logic [COEF_W-1:0]       slope_r;
  logic [COEF_W-1:0]       attack_r;
  logic [COEF_W-1:0]       release_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delay_r   <= RST_DELAY;
      fb_r      <= RST_FEEDBACK;
      mix_r     <= RST_MIX;
      thr_r     <= RST_THRESHOLD;
      slope_r   <= RST_SLOPE;
      attack_r  <= RST_ATTACK;
      release_r <= RST_RELEASE;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_DELAY:     delay_r   <= cfg_wdata[DELAY_W-1:0];
        REG_FEEDBACK:  fb_r      <= cfg_wdata[COEF_W-1:0];
        REG_MIX:       mix_r     <= cfg_wdata[GAIN_W-1:0];
        REG_THRESHOLD: thr_r     <= cfg_wdata[THR_W-1:0];
        REG_SLOPE:     slope_r   <= cfg_wdata[COEF_W-1:0];
        REG_ATTACK:    attack_r  <= cfg_wdata[COEF_W-1:0];
        REG_RELEASE:   release_r <= cfg_wdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  state_t        state_r, state_nxt;
  logic          ch_r, ch_nxt;
  logic [4:0]    k_r, k_nxt;
  logic [AW-1:0] wa_r, wa_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [SB-1:0] envl_r, envr_r;

  // payload
  logic signed [SB-1:0]    xl_r, xr_r, yl_r, yr_r;
  logic                    last_r;
  logic [DELAY_W-1:0]      dred_r;
  logic [AW-1:0]           raddr_r;
  logic                    rd_ok_r;
  logic signed [PW-1:0]    acc_r;
  logic signed [LOG_W-1:0] over_r;
  logic [GAIN_W-1:0]       gain_r;
  logic signed [SB-1:0]    out_l_r, out_r_r;
  logic                    out_last_r;

  logic                    accept;
  logic                    out_load;
  logic signed [MW-1:0]    mul_a;
  logic [GAIN_W-1:0]       mul_b;
  logic signed [PW-1:0]    prod;
  logic [SB-1:0]           dl_q, dr_q;

  assign accept   = in_valid && (state_r == S_IDLE);
  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // per-channel views
  logic signed [SB-1:0] x_cur, del_cur;
  logic [SB-1:0]        env_cur, abs_x;
  logic signed [SB:0]   x_ext;
  logic [COEF_W-1:0]    coef;

  always_comb begin
    x_cur   = ch_r ? xr_r : xl_r;
    env_cur = ch_r ? envr_r : envl_r;
    del_cur = rd_ok_r ? $signed(ch_r ? dr_q : dl_q) : '0;
    x_ext   = (SB+1)'(x_cur);
    abs_x   = SB'(x_ext[SB] ? -x_ext : x_ext);
    coef    = (abs_x > env_cur) ? attack_r : release_r;
  end

  // rounding of the multiplier output, floor((p + half) / 2^16)
  logic signed [PW-1:0] pr;
  logic signed [MW-1:0] rnd_w;
  assign pr    = prod + PW'(ROUND_HALF);
  assign rnd_w = MW'(pr >>> 16);

  // envelope update
  logic [PW:0]   env_sum;
  logic [SB-1:0] env_new;
  assign env_sum = {1'b0, acc_r} + {1'b0, prod} + (PW+1)'(ROUND_HALF);
  assign env_new = env_sum[SB+15:16];

  // log2 of the envelope in Q.8, linear mantissa
  logic [4:0]              top_p;
  logic [SB+7:0]           norm;
  logic [7:0]              frac;
  logic signed [LOG_W-1:0] lg;
  logic signed [LOG_W-1:0] over_new;

  always_comb begin
    top_p = '0;
    for (int k = 0; k < SB; k++) begin
      if (env_cur[k]) top_p = 5'(k);
    end
    norm = {env_cur, 8'b0} << (5'(SB - 1) - top_p);
    frac = norm[SB+6:SB-1];
    if (env_cur == '0) begin
      lg = $signed({8'd0 - 8'(SB - 1), 8'd0});
    end else begin
      lg = $signed({8'(top_p) - 8'(SB - 1), frac});
    end
    over_new = lg - LOG_W'(thr_r);
  end

  // gain = 2^(-reduction)
  logic [15:0]       red;
  logic [8:0]        ex;
  logic [9:0]        mant;
  logic [17:0]       sh;
  logic [GAIN_W-1:0] gain_new;

  always_comb begin
    red  = 16'(pr >>> 16);
    ex   = 9'(red[15:8]) + 9'(red[7:0] != 8'd0);
    mant = (red[7:0] != 8'd0) ? 10'd512 - 10'(red[7:0]) : 10'd256;
    sh   = {mant, 8'b0};
    if (over_r <= 0) begin
      gain_new = GAIN_W'(UNITY_GAIN);
    end else if (ex >= 9'd32) begin
      gain_new = '0;
    end else begin
      gain_new = GAIN_W'(sh >> ex[4:0]);
    end
  end

  // output sum with saturation
  logic signed [MW:0]   y_sum;
  logic signed [SB-1:0] y_sat;
  always_comb begin
    y_sum = (MW+1)'(x_cur) + (MW+1)'(rnd_w);
    priority if (y_sum > SMAX) y_sat = SB'(SMAX);
    else if (y_sum < SMIN)     y_sat = SB'(SMIN);
    else                       y_sat = SB'(y_sum);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_E1: begin
        mul_a = MW'({1'b0, abs_x});
        mul_b = GAIN_W'(UNITY_GAIN) - GAIN_W'(coef);
      end
      S_E2: begin
        mul_a = MW'({1'b0, env_cur});
        mul_b = GAIN_W'(coef);
      end
      S_G2: begin
        mul_a = MW'(over_r);
        mul_b = GAIN_W'(slope_r);
      end
      S_W1: begin
        mul_a = MW'(del_cur);
        mul_b = gain_r;
      end
      S_W2: begin
        mul_a = rnd_w;
        mul_b = GAIN_W'(fb_r);
      end
      S_W3: begin
        mul_a = rnd_w;
        mul_b = mix_r;
      end
      default: ;
    endcase
  end

  sdd_mul #(.A_W(MW)) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  sdd_line #(.DEPTH(DEPTH), .AW(AW), .W(SB)) u_line_l (
    .clk   (clk),
    .we    (state_r == S_WR),
    .waddr (wa_r),
    .wdata (xl_r),
    .re    (state_r == S_RD),
    .raddr (raddr_r),
    .rdata (dl_q)
  );

  sdd_line #(.DEPTH(DEPTH), .AW(AW), .W(SB)) u_line_r (
    .clk   (clk),
    .we    (state_r == S_WR),
    .waddr (wa_r),
    .wdata (xr_r),
    .re    (state_r == S_RD),
    .raddr (raddr_r),
    .rdata (dr_q)
  );

  // delay reduction and read address
  logic [17:0]   step_v;
  logic [RW-1:0] t_sum, t_mod;
  logic [AW-1:0] raddr_new;
  always_comb begin
    step_v    = 18'(DEPTH) << k_r;
    t_sum     = RW'(wa_r) + RW'(DEPTH) - RW'(dred_r);
    t_mod     = (t_sum >= RW'(DEPTH)) ? t_sum - RW'(DEPTH) : t_sum;
    raddr_new = t_mod[AW-1:0];
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    k_nxt         = k_r;
    wa_nxt        = wa_r;
    wrapped_nxt   = wrapped_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          k_nxt     = 5'(RED_STEPS) - 5'd1;
          state_nxt = (RED_STEPS > 0) ? S_RED : S_WR;
        end
      end
      S_RED: begin
        k_nxt = k_r - 5'd1;
        if (k_r == '0) state_nxt = S_WR;
      end
      S_WR: begin
        if (wa_r == AW'(DEPTH - 1)) begin
          wa_nxt      = '0;
          wrapped_nxt = 1'b1;
        end else begin
          wa_nxt = wa_r + 1'b1;
        end
        state_nxt = S_RD;
      end
      S_RD: begin
        ch_nxt    = 1'b0;
        state_nxt = S_E1;
      end
      S_E1: state_nxt = S_E2;
      S_E2: state_nxt = S_E3;
      S_E3: state_nxt = S_G1;
      S_G1: state_nxt = S_G2;
      S_G2: state_nxt = S_G3;
      S_G3: state_nxt = S_W1;
      S_W1: state_nxt = S_W2;
      S_W2: state_nxt = S_W3;
      S_W3: state_nxt = S_W4;
      S_W4: begin
        if (!ch_r) begin
          ch_nxt    = 1'b1;
          state_nxt = S_E1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      k_r         <= '0;
      wa_r        <= '0;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      envl_r      <= '0;
      envr_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      k_r         <= k_nxt;
      wa_r        <= wa_nxt;
      wrapped_r   <= wrapped_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_E3) begin
        if (ch_r) envr_r <= env_new;
        else      envl_r <= env_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xl_r   <= in_left_sample;
      xr_r   <= in_right_sample;
      last_r <= in_frame_last;
      dred_r <= delay_r;
    end
    if (state_r == S_RED && ({1'b0, dred_r} >= step_v)) begin
      dred_r <= dred_r - DELAY_W'(step_v);
    end
    if (state_r == S_WR) begin
      raddr_r <= raddr_new;
      // entries at or below the write address, or any after a wrap, were written
      rd_ok_r <= wrapped_r || (raddr_new <= wa_r);
    end
    if (state_r == S_E2) acc_r <= prod;
    if (state_r == S_G1) over_r <= over_new;
    if (state_r == S_G3) gain_r <= gain_new;
    if (state_r == S_W4) begin
      if (ch_r) yr_r <= y_sat;
      else      yl_r <= y_sat;
    end
    if (out_load) begin
      out_l_r    <= yl_r;
      out_r_r    <= yr_r;
      out_last_r <= last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_l_r;
  assign out_right_out = out_r_r;
  assign out_last      = out_last_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not stalled after accepted beat");

  a_env_l_range: assert property (@(posedge clk) disable iff (!rst_n)
    envl_r <= HALF)
    else $error("left envelope out of range");

  a_env_r_range: assert property (@(posedge clk) disable iff (!rst_n)
    envr_r <= HALF)
    else $error("right envelope out of range");

  a_wa_range: assert property (@(posedge clk) disable iff (!rst_n)
    wa_r <= AW'(DEPTH - 1))
    else $error("write address beyond depth");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("finished frame not presented");

endmodule

// ----- verif/stereo_ducking_delay_tb.sv -----
`timescale 1ns / 1ps
module stereo_ducking_delay_tb;
  import sdd_pkg::*;

  localparam int DEPTH     = 131072;
  localparam int SB        = 16;
  localparam int SETTLE    = 60;
  localparam int MAX_CYCLE = 2000000;
  localparam logic [CFG_AW-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic signed [SB-1:0] left;
    logic signed [SB-1:0] right;
    logic                 last;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid, in_stall, in_frame_last;
  logic signed [SB-1:0] in_left_sample, in_right_sample;
  logic out_valid, out_stall, out_last;
  logic signed [SB-1:0] out_left_out, out_right_out;
  logic cfg_we;
  logic [CFG_AW-1:0] cfg_addr;
  logic [CFG_DW-1:0] cfg_wdata;

  stereo_ducking_delay i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_left_sample (in_left_sample),
    .in_right_sample(in_right_sample),
    .in_frame_last  (in_frame_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_left_out   (out_left_out),
    .out_right_out  (out_right_out),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  initial forever #6 clk = ~clk;

  // shadow of the block state and registers
  logic signed [SB-1:0] left_hist [DEPTH];
  logic signed [SB-1:0] right_hist[DEPTH];
  int unsigned wr_ptr, env_l, env_r;
  int unsigned dly, fb, mix, slope, att, rel;
  int          thr;

  frame_t expected_frames[$];
  bit     failed = 1'b0;
  bit     calm   = 1'b0;
  int     cycles = 0;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic int unsigned envelope_next(int unsigned env, logic signed [SB-1:0] x);
    longint a, c;
    a = (x < 0) ? -longint'(x) : longint'(x);
    c = (a > env) ? att : rel;
    return int'((a * (65536 - c) + longint'(env) * c + 32768) >>> 16);
  endfunction

  function automatic int log2_q8(int unsigned env);
    int p;
    int unsigned frac;
    p = 0;
    if (env == 0) return -(SB - 1) * 256;
    while (p < 31 && (env >> (p + 1)) != 0) p++;
    if (p >= 8) frac = (env >> (p - 8)) & 255;
    else frac = (env << (8 - p)) & 255;
    return (p - (SB - 1)) * 256 + int'(frac);
  endfunction

  function automatic longint duck_gain(int unsigned env);
    longint over, red, i, f, e, m;
    over = longint'(log2_q8(env)) - thr;
    if (over <= 0) return 65536;
    red = (over * slope + 32768) >>> 16;
    i = red >>> 8;
    f = red & 255;
    e = (f != 0) ? i + 1 : i;
    m = (f != 0) ? 512 - f : 256;
    if (e >= 32) return 0;
    return (m << 8) >>> e;
  endfunction

  // delayed * gain * feedback * mix, each product rounded back by 2^16
  function automatic logic signed [SB-1:0] mix_channel(logic signed [SB-1:0] x,
      logic signed [SB-1:0] delayed, int unsigned env);
    longint w, y;
    w = (longint'(delayed) * duck_gain(env) + 32768) >>> 16;
    w = (w * longint'(fb) + 32768) >>> 16;
    w = (w * longint'(mix) + 32768) >>> 16;
    y = longint'(x) + w;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    return y[SB-1:0];
  endfunction

  function automatic void predict_frame(frame_t f);
    int unsigned rd;
    frame_t r;
    rd = (wr_ptr + DEPTH - (dly % DEPTH)) % DEPTH;
    env_l = envelope_next(env_l, f.left);
    env_r = envelope_next(env_r, f.right);
    left_hist[wr_ptr]  = f.left;
    right_hist[wr_ptr] = f.right;
    r.left  = mix_channel(f.left, left_hist[rd], env_l);
    r.right = mix_channel(f.right, right_hist[rd], env_r);
    r.last  = f.last;
    wr_ptr = (wr_ptr + 1) % DEPTH;
    expected_frames.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected output beat");
        failed = 1'b1;
      end else begin
        frame_t e;
        e = expected_frames.pop_front();
        if (out_left_out !== e.left) begin
          $error("left_out exp %0d got %0d", e.left, out_left_out);
          failed = 1'b1;
        end
        if (out_right_out !== e.right) begin
          $error("right_out exp %0d got %0d", e.right, out_right_out);
          failed = 1'b1;
        end
        if (out_last !== e.last) begin
          $error("out_last exp %0b got %0b", e.last, out_last);
          failed = 1'b1;
        end
      end
    end
  end

  // random back-pressure on the result side
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_frame(logic signed [SB-1:0] l, logic signed [SB-1:0] r, logic last);
    frame_t f;
    f.left = l;
    f.right = r;
    f.last = last;
    in_valid        <= 1'b1;
    in_left_sample  <= l;
    in_right_sample <= r;
    in_frame_last   <= last;
    do @(posedge clk); while (in_stall);
    predict_frame(f);
    if (!calm && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // waits for the block to drain, then writes one register
  task automatic write_reg(logic [CFG_AW-1:0] idx, int value);
    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[CFG_DW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DELAY:     dly   = value & 17'h1ffff;
      REG_FEEDBACK:  fb    = value & 16'hffff;
      REG_MIX:       mix   = value & 17'h1ffff;
      REG_THRESHOLD: thr   = int'($signed(value[THR_W-1:0]));
      REG_SLOPE:     slope = value & 16'hffff;
      REG_ATTACK:    att   = value & 16'hffff;
      REG_RELEASE:   rel   = value & 16'hffff;
      default: ;
    endcase
  endtask

  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
      1: return 16'sd0;
      2: return $signed(16'($urandom_range(0, 128))) - 16'sd64;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  task automatic test_default_extremes();
    send_frame(16'sd32767, -16'sd32768, 1'b0);
    send_frame(-16'sd32768, 16'sd32767, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b0);
    send_frame(-16'sd1, 16'sd1, 1'b1);
  endtask

  task automatic test_zero_delay_full_wet();
    write_reg(REG_DELAY, 0);
    write_reg(REG_FEEDBACK, 65535);
    write_reg(REG_MIX, 65536);
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_ATTACK, 0);
    write_reg(REG_RELEASE, 0);
    send_frame(16'sd32767, -16'sd32768, 1'b0);
    send_frame(16'sd20000, -16'sd20000, 1'b0);
    send_frame(16'sd1, -16'sd1, 1'b1);
    send_frame(16'sd0, 16'sd0, 1'b0);
  endtask

  task automatic test_ducking_extremes();
    write_reg(REG_DELAY, 2);
    write_reg(REG_THRESHOLD, -3840);
    write_reg(REG_SLOPE, 65535);
    write_reg(REG_MIX, 131071);
    write_reg(REG_UNUSED, 12345);
    send_frame(16'sd32767, 16'sd100, 1'b0);
    send_frame(-16'sd32768, 16'sd0, 1'b0);
    send_frame(16'sd4, -16'sd3, 1'b0);
    write_reg(REG_THRESHOLD, 4095);
    send_frame(16'sd32767, -16'sd32768, 1'b1);
    send_frame(16'sd12, 16'sd7, 1'b0);
  endtask

  task automatic test_delay_wrap();
    // delay of DEPTH-1 reads the slot just ahead of the write pointer
    write_reg(REG_DELAY, 131071);
    write_reg(REG_ATTACK, 65535);
    write_reg(REG_RELEASE, 65535);
    write_reg(REG_FEEDBACK, 0);
    send_frame(16'sd1000, -16'sd1000, 1'b0);
    write_reg(REG_FEEDBACK, 58982);
    write_reg(REG_SLOPE, 0);
    send_frame(16'sd32767, 16'sd32767, 1'b1);
    write_reg(REG_DELAY, 1);
    send_frame(-16'sd32768, -16'sd32768, 1'b0);
    send_frame(16'sd0, 16'sd0, 1'b1);
  endtask

  task automatic test_random_phases();
    int n;
    for (int ph = 0; ph < 14; ph++) begin
      if (ph == 11) calm = 1'b1;
      write_reg(REG_DELAY, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 131071)
                                                       : $urandom_range(0, 40));
      write_reg(REG_FEEDBACK, (ph % 4 == 0) ? 65535 : $urandom_range(0, 58982));
      write_reg(REG_MIX, (ph % 5 == 1) ? 131071 : $urandom_range(0, 65536));
      write_reg(REG_THRESHOLD, (ph % 6 == 2) ? $urandom_range(0, 4095)
                                             : -int'($urandom_range(0, 3840)));
      write_reg(REG_SLOPE, (ph % 3 == 0) ? 65535 : $urandom_range(0, 62259));
      write_reg(REG_ATTACK, (ph % 4 == 3) ? 0 : $urandom_range(0, 65535));
      write_reg(REG_RELEASE, (ph % 5 == 4) ? 65535 : $urandom_range(0, 65535));
      n = $urandom_range(90, 130);
      for (int k = 0; k < n; k++)
        send_frame(pick_sample(), pick_sample(), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_left_sample  <= '0;
    in_right_sample <= '0;
    in_frame_last   <= 1'b0;
    out_stall       <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_addr        <= '0;
    cfg_wdata       <= '0;
    for (int k = 0; k < DEPTH; k++) begin
      left_hist[k]  = '0;
      right_hist[k] = '0;
    end
    wr_ptr = 0; env_l = 0; env_r = 0;
    dly = 22050; fb = 19661; mix = 32768; thr = -850;
    slope = 49152; att = 65387; rel = 65521;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_extremes();
    test_zero_delay_full_wet();
    test_ducking_extremes();
    test_delay_wrap();
    test_random_phases();

    in_valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/sdd_pkg.sv
src/sdd_mul.sv
src/sdd_line.sv
src/stereo_ducking_delay.sv
verif/stereo_ducking_delay_tb.sv
